// ===== rtl/ehom_pkg.sv =====
// Package for the per-kind event-to-index map.
// Status codes, operation codes, register indexes, limits and defaults.
// No dependencies.
package ehom_pkg;

  localparam int unsigned KINDS_DEF       = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_KINDS = 2'd0,
    CFG_HMASK     = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_KIND = 3'd1,
    ST_RANGE    = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_NOT_SET  = 3'd4
  } status_e;

  localparam logic [15:0] MAX_SIMPLE_VALUE = 16'd32766;
  localparam int          MAX_OFFSET       = 16383;
  localparam logic [4:0]  NUM_KINDS_RST    = 5'd16;
  localparam logic [15:0] HMASK_RST        = 16'h0000;
  localparam logic [15:0] HANDLE_FULL      = 16'hFFFF;

endpackage

// ===== rtl/event_handle_offset_map.sv =====
// Per-kind event-to-index map, top level.
// The accepting edge sets in_vld_q, and in_vld_q sets the result strobe done_o through the register done_q.
// Throughput: one item per cycle; busy_o stays low, the table read/update sits in one stage.
// No backpressure on results: each result is shown for exactly one cycle.
// Reset: valid bits cleared, num_kinds = 16, mask = 0; payload storage is not reset.
// Depends on ehom_pkg.
module event_handle_offset_map #(
  parameter int unsigned KINDS       = ehom_pkg::KINDS_DEF,
  parameter int unsigned HANDLE_BITS = ehom_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           op_i,
  input  logic [7:0]                     kind_i,
  input  logic [15:0]                    handle_i,
  input  logic [15:0]                    value_i,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic signed [17:0]             result_value_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ehom_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ehom_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KW = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam logic [15:0] HMASK = (HANDLE_BITS >= 16) ? ehom_pkg::HANDLE_FULL :
                                  16'((32'd1 << HANDLE_BITS) - 32'd1);

  // config registers
  logic [4:0]  num_kinds_q;
  logic [15:0] hmask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_kinds_q <= ehom_pkg::NUM_KINDS_RST;
      hmask_q     <= ehom_pkg::HMASK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ehom_pkg::CFG_NUM_KINDS: num_kinds_q <= cfg_data_i[4:0];
        ehom_pkg::CFG_HMASK:     hmask_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_vld_q;
  logic        op_q;
  logic [7:0]  kind_q;
  logic [15:0] handle_q;
  logic [15:0] value_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q     <= op_i;
      kind_q   <= kind_i;
      handle_q <= handle_i & HMASK;
      value_q  <= value_i;
    end
  end

  // entry table
  logic        entry_valid_q [KINDS];
  logic [14:0] entry_payload_q [KINDS];

  logic [KW-1:0]      kidx;
  logic               bad_kind;
  logic               use_offset;
  logic               ent_vld;
  logic [14:0]        ent_pl;
  logic signed [16:0] off;
  logic [14:0]        new_pl;
  logic               in_range;
  logic               wr_en;
  ehom_pkg::status_e  status_d;
  logic signed [17:0] result_d;

  assign kidx     = kind_q[KW-1:0];
  assign bad_kind = (kind_q >= {3'b000, num_kinds_q}) || ({1'b0, kind_q} >= 9'(KINDS));
  // kinds beyond the 16 mask bits are always simple mode
  assign use_offset = (kind_q < 8'd16) && hmask_q[kind_q[3:0]];
  assign ent_vld    = entry_valid_q[kidx];
  assign ent_pl     = entry_payload_q[kidx];
  assign off        = $signed({1'b0, value_q}) - $signed({1'b0, handle_q});

  always_comb begin
    status_d = ehom_pkg::ST_OK;
    result_d = '0;
    wr_en    = 1'b0;
    if (use_offset) begin
      new_pl   = off[14:0];
      in_range = (off >= -17'sd16383) && (off <= 17'(ehom_pkg::MAX_OFFSET));
    end else begin
      new_pl   = value_q[14:0];
      in_range = (value_q <= ehom_pkg::MAX_SIMPLE_VALUE);
    end
    if (bad_kind) begin
      status_d = ehom_pkg::ST_BAD_KIND;
    end else if (op_q == ehom_pkg::OP_ADD) begin
      if (!in_range) begin
        status_d = ehom_pkg::ST_RANGE;
      end else if (!ent_vld) begin
        wr_en = in_vld_q;
      end else if (ent_pl != new_pl) begin
        status_d = ehom_pkg::ST_CONFLICT;
      end
    end else begin
      if (!ent_vld) begin
        status_d = ehom_pkg::ST_NOT_SET;
      end else if (use_offset) begin
        result_d = $signed({2'b00, handle_q}) + 18'($signed(ent_pl));
      end else begin
        result_d = $signed({3'b000, ent_pl});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(KINDS); i++) begin
        entry_valid_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      entry_valid_q[kidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_payload_q[kidx] <= new_pl;
    end
  end

  // result register
  logic               done_q;
  logic [2:0]         status_q;
  logic signed [17:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;

endmodule

// ===== rtl/ehom_checker.sv =====
// Port-level checker for the event-to-index map, bound to the top level.
// Timing of the result strobe and consistency of status and value.
// Depends on ehom_pkg.
module ehom_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           op_i,
  input logic                           done_o,
  input logic [2:0]                     status_o,
  input logic signed [17:0]             result_value_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_o)
    else $error("accepted beat produced no result");

  a_done_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 2))
    else $error("result without an accepted beat");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ehom_pkg::ST_OK) |-> (result_value_o == 18'sd0))
    else $error("failed item returned a nonzero value");

  a_add_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_i, 2) == ehom_pkg::OP_ADD) |->
      (result_value_o == 18'sd0 && status_o != ehom_pkg::ST_NOT_SET))
    else $error("add returned a value or not-set status");

  a_lookup_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_i, 2) == ehom_pkg::OP_LOOKUP) |->
      (status_o != ehom_pkg::ST_RANGE && status_o != ehom_pkg::ST_CONFLICT))
    else $error("lookup returned an add-only status");

endmodule

bind event_handle_offset_map ehom_checker u_ehom_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .op_i           (op_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .result_value_o (result_value_o)
);
